### hdl/i2c_master_bit_engine_assert.svh
// assertion macros shared by the i2c master bit engine
`ifndef I2C_MASTER_BIT_ENGINE_ASSERT_SVH
`define I2C_MASTER_BIT_ENGINE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define I2CBE_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define I2CBE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/i2cbe_pkg.sv
// types, codes and constants of the i2c master bit engine
package i2cbe_pkg;

    localparam int DELAY_WIDTH_DEF = 16;
    localparam int CFG_WIDTH       = 16;
    localparam logic [CFG_WIDTH-1:0] DELAY_RESET = 16'd4;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    typedef enum logic [2:0] {
        OP_NONE   = 3'd0,
        OP_START  = 3'd1,
        OP_STOP   = 3'd2,
        OP_WRITE  = 3'd3,
        OP_READ   = 3'd4,
        OP_MACK   = 3'd5,
        OP_MNACK  = 3'd6,
        OP_ACKCLK = 3'd7
    } op_t;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] tx_byte;
        logic       sda_in;
    } in_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic [7:0] rx_byte;
        logic       rx_valid;
        logic       busy_res;
        logic       command_dropped;
    } out_t;

    // decoded item as queued between front and back
    typedef struct packed {
        op_t        op;
        logic       has_cmd;
        logic [1:0] last_phase;
        logic       byte_cmd;
        logic [7:0] tx_byte;
        logic       sda_in;
    } q_item_t;

endpackage

### hdl/i2cbe_front.sv
// front end: takes tick items, decodes the command, queues them for the engine
module i2cbe_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  i2cbe_pkg::in_t    s_data,
    output logic              q_valid,
    input  logic              q_ready,
    output i2cbe_pkg::q_item_t q_item
);
    import i2cbe_pkg::*;

    q_item_t              ent_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]   cnt_reg, cnt_next;
    q_item_t              dec;
    logic                 push, pop;

    // classify the opcode
    always_comb begin
        dec.op         = op_t'(s_data.opcode);
        dec.has_cmd    = (op_t'(s_data.opcode) != OP_NONE);
        dec.tx_byte    = s_data.tx_byte;
        dec.sda_in     = s_data.sda_in;
        case (op_t'(s_data.opcode)) inside
            OP_START, OP_MACK: dec.last_phase = 2'd3;
            default:           dec.last_phase = 2'd2;
        endcase
        case (op_t'(s_data.opcode)) inside
            OP_WRITE, OP_READ: dec.byte_cmd = 1'b1;
            default:           dec.byte_cmd = 1'b0;
        endcase
    end

    assign s_ready = (cnt_reg != Q_CNT_W'(Q_DEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_item  = ent_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wr_ptr_reg] <= dec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

### hdl/i2cbe_back.sv
// back end: phase/wait engine driving scl and sda, one queued item per cycle unless a low m_ready stalls the output
module i2cbe_back #(
    parameter int DELAY_WIDTH = i2cbe_pkg::DELAY_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [i2cbe_pkg::CFG_WIDTH-1:0] cfg_wr_data,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  i2cbe_pkg::q_item_t            q_item,
    output logic                          eng_fire,
    output logic                          m_valid,
    input  logic                          m_ready,
    output i2cbe_pkg::out_t               m_data
);
    import i2cbe_pkg::*;

    logic [DELAY_WIDTH-1:0] delay_reg;
    logic [DELAY_WIDTH-1:0] eff_delay;

    op_t                    cmd_reg, cmd_next;
    logic [1:0]             last_reg, last_next;
    logic                   byte_reg, byte_next;
    logic [1:0]             phase_reg, phase_next;
    logic [2:0]             bit_reg, bit_next;
    logic [DELAY_WIDTH-1:0] wait_reg, wait_next;
    logic [7:0]             shift_reg, shift_next;
    logic                   scl_reg, scl_next;
    logic                   sda_reg, sda_next;
    logic [7:0]             rx_reg, rx_next;
    logic                   rxv, drop, do_act;

    logic                   m_valid_reg, m_valid_next;
    out_t                   m_data_reg;

    assign eff_delay = (delay_reg == '0) ? DELAY_WIDTH'(1) : delay_reg;
    assign q_ready   = !m_valid_reg || m_ready;
    assign eng_fire  = q_valid && q_ready;

    always_comb begin
        cmd_next   = cmd_reg;
        last_next  = last_reg;
        byte_next  = byte_reg;
        phase_next = phase_reg;
        bit_next   = bit_reg;
        wait_next  = wait_reg;
        shift_next = shift_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        rx_next    = rx_reg;
        rxv        = 1'b0;
        drop       = 1'b0;
        do_act     = 1'b0;

        // advance the running command
        if (cmd_reg != OP_NONE) begin
            if (wait_reg > DELAY_WIDTH'(1)) begin
                wait_next = wait_reg - 1'b1;
            end else if (phase_reg == last_reg && (!byte_reg || bit_reg == 3'd7)) begin
                if (cmd_reg == OP_READ) begin
                    rx_next = shift_reg;
                    rxv     = 1'b1;
                end
                cmd_next   = OP_NONE;
                phase_next = '0;
                bit_next   = '0;
                wait_next  = '0;
            end else begin
                if (phase_reg == last_reg) begin
                    phase_next = '0;
                    bit_next   = bit_reg + 1'b1;
                end else begin
                    phase_next = phase_reg + 1'b1;
                end
                do_act = 1'b1;
            end
            if (cmd_next != OP_NONE && q_item.has_cmd) begin
                drop = 1'b1;
            end
        end

        // idle by now: take this tick's command
        if (cmd_next == OP_NONE && q_item.has_cmd) begin
            cmd_next   = q_item.op;
            last_next  = q_item.last_phase;
            byte_next  = q_item.byte_cmd;
            phase_next = '0;
            bit_next   = '0;
            if (q_item.op == OP_WRITE) begin
                shift_next = q_item.tx_byte;
            end
            do_act = 1'b1;
        end

        // line change of the current phase
        if (do_act) begin
            case (cmd_next)
                OP_START: begin
                    case (phase_next)
                        2'd0:    sda_next = 1'b1;
                        2'd1:    scl_next = 1'b1;
                        2'd2:    sda_next = 1'b0;
                        default: scl_next = 1'b0;
                    endcase
                end
                OP_STOP: begin
                    case (phase_next)
                        2'd0:    sda_next = 1'b0;
                        2'd1:    scl_next = 1'b1;
                        default: sda_next = 1'b1;
                    endcase
                end
                OP_WRITE: begin
                    case (phase_next)
                        2'd0: begin
                            sda_next   = shift_next[7];
                            shift_next = {shift_next[6:0], 1'b0};
                        end
                        2'd1:    scl_next = 1'b1;
                        default: scl_next = 1'b0;
                    endcase
                end
                OP_READ: begin
                    case (phase_next)
                        2'd0:    scl_next = 1'b1;
                        2'd1:    shift_next = {shift_reg[6:0], q_item.sda_in};
                        default: scl_next = 1'b0;
                    endcase
                end
                OP_MACK: begin
                    case (phase_next)
                        2'd0:    sda_next = 1'b0;
                        2'd1:    scl_next = 1'b1;
                        2'd2:    scl_next = 1'b0;
                        default: sda_next = 1'b1;
                    endcase
                end
                default: begin
                    case (phase_next)
                        2'd0:    sda_next = 1'b1;
                        2'd1:    scl_next = 1'b1;
                        default: scl_next = 1'b0;
                    endcase
                end
            endcase
            wait_next = eff_delay;
        end
    end

    assign m_valid_next = eng_fire ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg   <= DELAY_WIDTH'(DELAY_RESET);
            cmd_reg     <= OP_NONE;
            last_reg    <= 2'd2;
            byte_reg    <= 1'b0;
            phase_reg   <= '0;
            bit_reg     <= '0;
            wait_reg    <= '0;
            shift_reg   <= '0;
            scl_reg     <= 1'b1;
            sda_reg     <= 1'b1;
            rx_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                delay_reg <= DELAY_WIDTH'(cfg_wr_data);
            end
            if (eng_fire) begin
                cmd_reg   <= cmd_next;
                last_reg  <= last_next;
                byte_reg  <= byte_next;
                phase_reg <= phase_next;
                bit_reg   <= bit_next;
                wait_reg  <= wait_next;
                shift_reg <= shift_next;
                scl_reg   <= scl_next;
                sda_reg   <= sda_next;
                rx_reg    <= rx_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (eng_fire) begin
            m_data_reg.scl_out         <= scl_next;
            m_data_reg.sda_out         <= sda_next;
            m_data_reg.rx_byte         <= rx_next;
            m_data_reg.rx_valid        <= rxv;
            m_data_reg.busy_res        <= (cmd_next != OP_NONE);
            m_data_reg.command_dropped <= drop;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### hdl/i2c_master_bit_engine.sv
// top level of the i2c master bit engine: front queue, line engine, checks
//
//  port group        | dir | handshake          | carries
//  ------------------+-----+--------------------+---------------------------------
//  s_valid/s_data    | in  | s_valid / s_ready  | one tick: opcode, tx_byte, sda_in
//  m_valid/m_data    | out | m_valid / m_ready  | one result per tick: lines, rx, flags
//  cfg_wr_en/_data   | in  | write enable only  | delay_ticks
//
//  one tick item in and one result item out per clock when both sides flow
//  each item is registered in a queue entry, then the engine step registers it into the output register
//  the engine advances once per item, so line timing counts items, not clocks
//  reset (synchronous, aresetn low) releases both lines high, delay 4, queue empty
//  a stalled m_ready backs up into the two-entry queue before s_ready drops
`include "i2c_master_bit_engine_assert.svh"

module i2c_master_bit_engine #(
    parameter int DELAY_WIDTH = i2cbe_pkg::DELAY_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  i2cbe_pkg::in_t                  s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output i2cbe_pkg::out_t                 m_data,
    input  logic                            cfg_wr_en,
    input  logic [i2cbe_pkg::CFG_WIDTH-1:0] cfg_wr_data
);
    import i2cbe_pkg::*;

    // queue side between decode and engine
    logic    q_valid;
    logic    q_ready;
    q_item_t q_item;
    // engine took an item this cycle
    logic    eng_fire;

    // front: decode the opcode and hold items while the engine stalls
    i2cbe_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item)
    );

    // back: phase and wait counters, line levels, read shifter, output register
    i2cbe_back #(
        .DELAY_WIDTH (DELAY_WIDTH)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_item      (q_item),
        .eng_fire    (eng_fire),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    // a dropped command only happens while a command keeps running
    `I2CBE_ASSERT_NOW(a_drop_busy, aclk, aresetn, m_valid && m_data.command_dropped, m_data.busy_res, "drop flagged while idle")
    // input back-pressure only when the queue holds something
    `I2CBE_ASSERT_NOW(a_full_queue, aclk, aresetn, !s_ready, q_valid, "s_ready low with empty queue")
    // every engine step lands in the output register
    `I2CBE_ASSERT_NEXT(a_step_out, aclk, aresetn, eng_fire, m_valid, "engine step lost")

endmodule
